// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the checked modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define CHK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication, quiet while reset is held
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ----- rtl/core/cc20_pkg.sv -----
// types, constants and state helpers for the chacha20 block engine
package cc20_pkg;

  typedef logic [15:0][31:0] state_t;
  typedef logic [7:0][63:0]  data_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY_0_7       = 3'd0,
    REG_KEY_8_15      = 3'd1,
    REG_KEY_16_23     = 3'd2,
    REG_KEY_24_31     = 3'd3,
    REG_KEY_IS_256    = 3'd4,
    REG_COUNTER_START = 3'd5,
    REG_NONCE_TAIL    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [63:0] key2;
    logic [63:0] key3;
    logic        key_256;
    logic [63:0] nonce;
  } cfg_t;

  typedef struct packed {
    state_t      x;
    data_t       data;
    logic [63:0] ctr;
    logic [6:0]  cnt;
  } item_t;

  // "expand 32-byte k" and "expand 16-byte k", word 0 lowest
  localparam logic [3:0][31:0] SIGMA32 =
    {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
  localparam logic [3:0][31:0] SIGMA16 =
    {32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865};

  // initial state from configuration and block counter
  function automatic state_t build_init(cfg_t c, logic [63:0] ctr);
    state_t s;
    s[3:0]   = c.key_256 ? SIGMA32 : SIGMA16;
    s[5:4]   = c.key0;
    s[7:6]   = c.key1;
    s[9:8]   = c.key_256 ? c.key2 : c.key0;
    s[11:10] = c.key_256 ? c.key3 : c.key1;
    s[13:12] = ctr;
    s[15:14] = c.nonce;
    return s;
  endfunction

  // rotate rows 1..3 so diagonals line up as columns
  function automatic item_t diag_item(item_t it);
    item_t o;
    o = it;
    for (int j = 0; j < 4; j++) begin
      o.x[4 + j]  = it.x[4 + ((j + 1) % 4)];
      o.x[8 + j]  = it.x[8 + ((j + 2) % 4)];
      o.x[12 + j] = it.x[12 + ((j + 3) % 4)];
    end
    return o;
  endfunction

  // undo the diagonal rotation
  function automatic item_t undiag_item(item_t it);
    item_t o;
    o = it;
    for (int j = 0; j < 4; j++) begin
      o.x[4 + ((j + 1) % 4)]  = it.x[4 + j];
      o.x[8 + ((j + 2) % 4)]  = it.x[8 + j];
      o.x[12 + ((j + 3) % 4)] = it.x[12 + j];
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/chacha20_stream_cipher_top.sv -----
// chacha20 block engine: one round per stage plus the output register; throughput is
// one 64-byte word per cycle while out_tready does not stall the output, set by the
// round pipeline whose stages each hold four quarter-round lanes.
// a word with zero byte count yields no result; the counter holds unless it restarts.
// synchronous active-low reset clears the pipeline, counter and registers
// (key size resets to 256 bits); no clearing pass is needed.
module chacha20_stream_cipher_top
  import cc20_pkg::*;
#(
  parameter int ROUNDS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [519:0] in_tdata,   // data_word_0..7, byte_count, pad
  input  logic [0:0]   in_tuser,   // restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [519:0] out_tdata,  // result_word_0..7, result_byte_count, pad
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  localparam int NSTAGE = (ROUNDS / 2) * 2;

  cfg_t        cfg_r;
  logic [63:0] ctr_start_r;
  logic [63:0] blk_ctr_r;
  logic [63:0] blk_ctr_nxt;
  logic [63:0] ctr_sel;
  logic [6:0]  cnt_raw;
  logic [6:0]  cnt_sat;
  logic        restart;
  logic        in_acc;
  item_t       in_item;

  item_t st_in  [NSTAGE];
  item_t st_out [NSTAGE];
  item_t st_fix [NSTAGE];
  logic  st_in_valid  [NSTAGE];
  logic  st_in_ready  [NSTAGE];
  logic  st_out_valid [NSTAGE];
  logic  st_out_ready [NSTAGE];

  logic  mrg_ready;
  data_t out_data;
  logic [6:0] out_cnt;

  // input word fields
  assign cnt_raw = in_tdata[518:512];
  assign restart = in_tuser[0];
  assign cnt_sat = (cnt_raw > 7'd64) ? 7'd64 : cnt_raw;
  assign in_acc  = in_tvalid && in_tready;

  // block counter for this word and the next
  assign ctr_sel     = restart ? ctr_start_r : blk_ctr_r;
  assign blk_ctr_nxt = (cnt_raw == 7'd0) ? ctr_sel : ctr_sel + 64'd1;

  // configuration and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key0    <= 64'd0;
      cfg_r.key1    <= 64'd0;
      cfg_r.key2    <= 64'd0;
      cfg_r.key3    <= 64'd0;
      cfg_r.key_256 <= 1'b1;
      cfg_r.nonce   <= 64'd0;
      ctr_start_r   <= 64'd0;
      blk_ctr_r     <= 64'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_0_7:       cfg_r.key0    <= cfg_wdata;
          REG_KEY_8_15:      cfg_r.key1    <= cfg_wdata;
          REG_KEY_16_23:     cfg_r.key2    <= cfg_wdata;
          REG_KEY_24_31:     cfg_r.key3    <= cfg_wdata;
          REG_KEY_IS_256:    cfg_r.key_256 <= cfg_wdata[0];
          REG_COUNTER_START: ctr_start_r   <= cfg_wdata;
          REG_NONCE_TAIL:    cfg_r.nonce   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        blk_ctr_r <= blk_ctr_nxt;
      end
    end
  end

  // item entering the round pipeline
  assign in_item.x    = build_init(cfg_r, ctr_sel);
  assign in_item.data = data_t'(in_tdata[511:0]);
  assign in_item.ctr  = ctr_sel;
  assign in_item.cnt  = cnt_sat;

  // round pipeline; odd stages work on diagonals via a row rotation
  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_in[k]       = in_item;
      assign st_in_valid[k] = in_tvalid && (cnt_raw != 7'd0);
    end else if (k % 2 == 1) begin : g_odd_in
      assign st_in[k]       = diag_item(st_fix[k - 1]);
      assign st_in_valid[k] = st_out_valid[k - 1];
    end else begin : g_even_in
      assign st_in[k]       = st_fix[k - 1];
      assign st_in_valid[k] = st_out_valid[k - 1];
    end

    if (k % 2 == 1) begin : g_odd_out
      assign st_fix[k] = undiag_item(st_out[k]);
    end else begin : g_even_out
      assign st_fix[k] = st_out[k];
    end

    if (k == NSTAGE - 1) begin : g_last
      assign st_out_ready[k] = mrg_ready;
    end else begin : g_mid
      assign st_out_ready[k] = st_in_ready[k + 1];
    end

    cc20_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_in_valid[k]),
      .in_item   (st_in[k]),
      .in_ready  (st_in_ready[k]),
      .out_valid (st_out_valid[k]),
      .out_item  (st_out[k]),
      .out_ready (st_out_ready[k])
    );
  end

  assign in_tready = st_in_ready[0];

  // merge lanes with the initial state and the data
  cc20_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (st_out_valid[NSTAGE - 1]),
    .in_item   (st_fix[NSTAGE - 1]),
    .in_ready  (mrg_ready),
    .out_valid (out_tvalid),
    .out_data  (out_data),
    .out_cnt   (out_cnt),
    .out_ready (out_tready)
  );

  assign out_tdata = {1'b0, out_cnt, out_data};

  // checks
  `include "assert_macros.svh"

  `CHK_NEXT(a_zero_cnt_holds_ctr, in_acc && (cnt_raw == 7'd0) && !restart,
            blk_ctr_r == $past(blk_ctr_r))
  `CHK_NEXT(a_ctr_advances, in_acc && (cnt_raw != 7'd0) && !restart,
            blk_ctr_r == $past(blk_ctr_r) + 64'd1)
  `CHK_NOW(a_out_cnt_range, out_tvalid, (out_cnt != 7'd0) && (out_cnt <= 7'd64))

endmodule

// ----- rtl/core/cc20_qr.sv -----
// one chacha quarter-round lane
module cc20_qr
  import cc20_pkg::*;
(
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);

  logic [31:0] a1, b1, c1, d1, t1, u1;
  logic [31:0] t2, u2;

  // first half: rotate by 16 and 12
  assign a1 = a_i + b_i;
  assign t1 = d_i ^ a1;
  assign d1 = {t1[15:0], t1[31:16]};
  assign c1 = c_i + d1;
  assign u1 = b_i ^ c1;
  assign b1 = {u1[19:0], u1[31:20]};

  // second half: rotate by 8 and 7
  assign a_o = a1 + b1;
  assign t2  = d1 ^ a_o;
  assign d_o = {t2[23:0], t2[31:24]};
  assign c_o = c1 + d_o;
  assign u2  = b1 ^ c_o;
  assign b_o = {u2[24:0], u2[31:25]};

endmodule

// ----- rtl/core/cc20_round.sv -----
// one pipelined round: four quarter-round lanes over the state columns
module cc20_round
  import cc20_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  output logic  out_valid,
  output item_t out_item,
  input  logic  out_ready
);

  logic [31:0] rx [16];
  item_t       item_nxt;
  item_t       item_r;
  logic        valid_r;

  // four lanes, one per column
  for (genvar j = 0; j < 4; j++) begin : g_lane
    cc20_qr u_qr (
      .a_i (in_item.x[j]),
      .b_i (in_item.x[4 + j]),
      .c_i (in_item.x[8 + j]),
      .d_i (in_item.x[12 + j]),
      .a_o (rx[j]),
      .b_o (rx[4 + j]),
      .c_o (rx[8 + j]),
      .d_o (rx[12 + j])
    );
  end

  // gather lane results
  always_comb begin
    item_nxt = in_item;
    for (int i = 0; i < 16; i++) begin
      item_nxt.x[i] = rx[i];
    end
  end

  // stage register, moves when empty or when the next stage takes it
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ----- rtl/core/cc20_merge.sv -----
// final add of the initial state, data xor and byte masking
module cc20_merge
  import cc20_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  item_t      in_item,
  output logic       in_ready,
  output logic       out_valid,
  output data_t      out_data,
  output logic [6:0] out_cnt,
  input  logic       out_ready
);

  state_t      init;
  state_t      ks;
  data_t       res_nxt;
  data_t       res_r;
  logic [6:0]  cnt_r;
  logic        valid_r;

  // rebuild the initial state; the user must keep configuration steady while items fly, not enforced here
  assign init = build_init(cfg, in_item.ctr);

  // keystream, xor, and zero the bytes at or past the count
  always_comb begin
    for (int w = 0; w < 16; w++) begin
      ks[w] = in_item.x[w] + init[w];
    end
    res_nxt = in_item.data ^ data_t'(ks);
    for (int b = 0; b < 64; b++) begin
      if (7'(b) >= in_item.cnt) begin
        res_nxt[b / 8][(b % 8) * 8 +: 8] = 8'h00;
      end
    end
  end

  // output register
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
      cnt_r <= in_item.cnt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;
  assign out_cnt   = cnt_r;

endmodule

// ----- dv/chacha20_stream_cipher_top_test.sv -----
// testbench for the chacha20 block engine: directed and random words checked against a predictor
module chacha20_stream_cipher_top_test
  import cc20_pkg::*;
();

  localparam int ROUNDS = 20;
  localparam int CLK_PERIOD = 12;
  localparam int LATENCY = 2 * (ROUNDS / 2) + 1;

  typedef logic [15:0][31:0] words16_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic             wide;
    logic [63:0]      ctr_start;
    logic [63:0]      nonce;
  } cipher_cfg_t;

  typedef struct packed {
    logic [511:0] words;
    logic [6:0]   count;
  } cipher_block_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [519:0] in_tdata = '0;   // data_word_0..7, byte_count, pad
  logic [0:0]   in_tuser = '0;   // restart
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [519:0] out_tdata;       // result_word_0..7, result_byte_count, pad
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_wdata = '0;

  // predictor state
  cipher_cfg_t   cur_cfg;
  logic [63:0]   blk_ctr;
  cipher_block_t expected_blocks[$];

  int  error_count = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;
  int  stall_left = 0;

  chacha20_stream_cipher_top #(.ROUNDS(ROUNDS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  initial begin
    #(CLK_PERIOD * 400000);
    $display("chacha20_stream_cipher_top_test: done, errors");
    $finish;
  end

  function automatic logic [31:0] rotl32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic words16_t quarter(words16_t s, int a, int b, int c, int d);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 7);
    return s;
  endfunction

  // 64-byte keystream for one counter value, word 0 in the low bits
  function automatic logic [511:0] keystream_block(cipher_cfg_t c, logic [63:0] ctr);
    words16_t init;
    words16_t x;
    init[3:0]   = c.wide ? SIGMA32 : SIGMA16;
    init[5:4]   = c.key[0];
    init[7:6]   = c.key[1];
    init[9:8]   = c.wide ? c.key[2] : c.key[0];
    init[11:10] = c.wide ? c.key[3] : c.key[1];
    init[13:12] = ctr;
    init[15:14] = c.nonce;
    x = init;
    for (int r = 0; r < ROUNDS / 2; r++) begin
      x = quarter(x, 0, 4, 8, 12);
      x = quarter(x, 1, 5, 9, 13);
      x = quarter(x, 2, 6, 10, 14);
      x = quarter(x, 3, 7, 11, 15);
      x = quarter(x, 0, 5, 10, 15);
      x = quarter(x, 1, 6, 11, 12);
      x = quarter(x, 2, 7, 8, 13);
      x = quarter(x, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) x[i] = x[i] + init[i];
    return x;
  endfunction

  // expected result of one accepted word, counter update included
  task automatic predict_block(logic [511:0] data, logic [6:0] cnt, logic restart);
    cipher_block_t res;
    logic [6:0] used;
    if (restart) blk_ctr = cur_cfg.ctr_start;
    if (cnt == 7'd0) return;
    used = (cnt > 7'd64) ? 7'd64 : cnt;
    res.words = data ^ keystream_block(cur_cfg, blk_ctr);
    for (int b = 0; b < 64; b++)
      if (b >= used) res.words[8 * b +: 8] = 8'h00;
    res.count = used;
    expected_blocks.push_back(res);
    blk_ctr = blk_ctr + 64'd1;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [511:0] rand512();
    logic [511:0] v;
    for (int i = 0; i < 8; i++) v[64 * i +: 64] = rand64();
    return v;
  endfunction

  // send one word, wait for acceptance, then predict it
  task automatic send_block(logic [511:0] data, logic [6:0] cnt, logic restart);
    while (tx_idle_on && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, cnt, data};
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_block(data, cnt, restart);
  endtask

  // stop sending, let every expected result arrive and the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // write all registers, only while idle
  task automatic write_cfg(cipher_cfg_t c);
    cfg_reg_t r;
    logic [63:0] v;
    logic [31:0] rnd;
    for (int i = 0; i <= REG_NONCE_TAIL; i++) begin
      r = cfg_reg_t'(i);
      case (r)
        REG_KEY_0_7:       v = c.key[0];
        REG_KEY_8_15:      v = c.key[1];
        REG_KEY_16_23:     v = c.key[2];
        REG_KEY_24_31:     v = c.key[3];
        REG_KEY_IS_256: begin
          rnd = $urandom;
          v = {$urandom, rnd[30:0], c.wide};
        end
        REG_COUNTER_START: v = c.ctr_start;
        default:           v = c.nonce;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic cipher_cfg_t rand_cfg();
    cipher_cfg_t c;
    for (int i = 0; i < 4; i++) c.key[i] = rand64();
    c.wide = 1'($urandom_range(1));
    // start near the wrap point now and then
    c.ctr_start = ($urandom_range(3) == 0) ? ~64'($urandom_range(3)) : rand64();
    c.nonce = rand64();
    return c;
  endfunction

  // compare one accepted result with the oldest expectation
  task automatic check_block();
    cipher_block_t want;
    cipher_block_t got;
    got.words = out_tdata[511:0];
    got.count = out_tdata[518:512];
    if (expected_blocks.size() == 0) begin
      $display("%0t: unexpected result word, got %h count %0d", $time, got.words, got.count);
      error_count++;
      return;
    end
    want = expected_blocks.pop_front();
    for (int i = 0; i < 8; i++)
      if (got.words[64 * i +: 64] !== want.words[64 * i +: 64]) begin
        $display("%0t: result_word_%0d expected %h got %h", $time, i,
                 want.words[64 * i +: 64], got.words[64 * i +: 64]);
        error_count++;
      end
    if (got.count !== want.count) begin
      $display("%0t: result_byte_count expected %0d got %0d", $time, want.count, got.count);
      error_count++;
    end
  endtask

  // result side: check accepted words, then pick the next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_block();
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!rx_idle_on) begin
        out_tready <= 1'b1;
      end else if ($urandom_range(199) == 0) begin
        // long stall, enough to fill the round pipeline
        stall_left = $urandom_range(30, 60);
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // reset values, all-zero and all-one data
  task automatic test_defaults();
    send_block('0, 7'd64, 1'b0);
    send_block('1, 7'd64, 1'b0);
  endtask

  // partial, full, zero and oversize byte counts
  task automatic test_byte_counts();
    logic [6:0] counts[11] = '{7'd1, 7'd7, 7'd8, 7'd9, 7'd63, 7'd64, 7'd65, 7'd127,
                               7'd0, 7'd0, 7'd32};
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 11; i++)
      send_block(rand512(), counts[i], (i == 8));
  endtask

  // counter wrap to zero and carry from word 12 into word 13
  task automatic test_counter_wrap();
    cipher_cfg_t c;
    settle();
    c = rand_cfg();
    c.wide = 1'b1;
    c.ctr_start = '1;
    c.nonce = '1;
    write_cfg(c);
    send_block(rand512(), 7'd64, 1'b1);
    send_block(rand512(), 7'd64, 1'b0);
    send_block(rand512(), 7'd64, 1'b0);
    settle();
    c.ctr_start = 64'h0000_0000_ffff_ffff;
    c.nonce = 64'h0;
    write_cfg(c);
    send_block(rand512(), 7'd64, 1'b1);
    send_block(rand512(), 7'd64, 1'b0);
  endtask

  // 128-bit key with extreme key values
  task automatic test_short_key();
    cipher_cfg_t c;
    settle();
    c.key = '1;
    c.wide = 1'b0;
    c.ctr_start = '0;
    c.nonce = '0;
    write_cfg(c);
    send_block('1, 7'd64, 1'b1);
    send_block(rand512(), 7'd40, 1'b0);
    settle();
    c.key = '0;
    write_cfg(c);
    send_block('0, 7'd64, 1'b1);
  endtask

  // random settings, full words most often, some partial, zero and oversize counts
  task automatic test_random_phases();
    cipher_cfg_t c;
    int n;
    int pick;
    logic [6:0] cnt;
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      c = rand_cfg();
      write_cfg(c);
      // first phase runs without any idling on either side
      tx_idle_on = (ph != 0);
      rx_idle_on = (ph != 0);
      n = (ph == 0) ? 300 : 140;
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(99);
        if (pick < 45)      cnt = 7'd64;
        else if (pick < 80) cnt = 7'($urandom_range(1, 64));
        else if (pick < 88) cnt = 7'd0;
        else if (pick < 94) cnt = 7'($urandom_range(65, 127));
        else                cnt = 7'($urandom_range(1, 8));
        send_block(rand512(), cnt, ($urandom_range(15) == 0));
        // sender pause until the pipeline has drained
        if (ph == 3 && i == n / 2) settle();
      end
    end
  endtask

  initial begin
    cur_cfg.key = '0;
    cur_cfg.wide = 1'b1;
    cur_cfg.ctr_start = '0;
    cur_cfg.nonce = '0;
    blk_ctr = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_byte_counts();
    test_counter_wrap();
    test_short_key();
    test_random_phases();
    settle();
    if (error_count == 0) begin
      $display("chacha20_stream_cipher_top_test: done, clean");
    end else begin
      $display("chacha20_stream_cipher_top_test: done, errors");
    end
    $finish;
  end

endmodule
